>>> rtl/utcloc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utcloc_pkg
// Types, month table and leap-year helper for the UTC to local calendar block.
// ----------------------------------------------------------------------------
package utcloc_pkg;

    typedef logic [13:0]        t_year;
    typedef logic [7:0]         t_raw_month;
    typedef logic [3:0]         t_month;
    typedef logic [4:0]         t_day;
    typedef logic [4:0]         t_hour;
    typedef logic signed [4:0]  t_offset;

    localparam t_month MONTH_JAN = 4'd1;
    localparam t_month MONTH_FEB = 4'd2;
    localparam t_month MONTH_DEC = 4'd12;

    localparam t_day MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // y % 25 == 0 by folding powers of two: 128 = 3 (mod 25), 32 = 7 (mod 25)
    function automatic logic div_by_25(input t_year y);
        logic [8:0] s1;
        logic [7:0] s2;
        logic [5:0] s3;
        s1 = 9'(y[13:7]) * 9'd3 + 9'(y[6:0]);
        s2 = 8'(s1[8:5]) * 8'd7 + 8'(s1[4:0]);
        s3 = 6'(s2[7:5]) * 6'd7 + 6'(s2[4:0]);
        return (s3 == 6'd0) || (s3 == 6'd25) || (s3 == 6'd50);
    endfunction

    // Gregorian rule; divisible by 400 is divisible by 16 and by 25
    function automatic logic is_leap(input t_year y);
        logic d25;
        d25 = div_by_25(y);
        return (y[1:0] == 2'b00) && (!d25 || (y[3:0] == 4'd0));
    endfunction

    // month is 1..12
    function automatic t_day month_days(input t_month m, input logic leap);
        t_day d;
        d = MONTH_LEN[4'(m - 4'd1)];
        if (m == MONTH_FEB && leap) begin
            d = 5'd29;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

>>> rtl/utcloc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utcloc_in_if
// Valid/ready channel carrying one UTC date and hour.
// ----------------------------------------------------------------------------
interface utcloc_in_if;
    logic                   valid;
    logic                   ready;
    utcloc_pkg::t_year      utc_year;
    utcloc_pkg::t_raw_month utc_month;
    utcloc_pkg::t_day       utc_day;
    utcloc_pkg::t_hour      utc_hour;

    modport source (output valid, output utc_year, output utc_month,
                    output utc_day, output utc_hour, input ready);
    modport sink   (input valid, input utc_year, input utc_month,
                    input utc_day, input utc_hour, output ready);
endinterface
`default_nettype wire

>>> rtl/utcloc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utcloc_out_if
// Valid/ready channel carrying one local date and hour.
// ----------------------------------------------------------------------------
interface utcloc_out_if;
    logic               valid;
    logic               ready;
    utcloc_pkg::t_year  local_year;
    utcloc_pkg::t_month local_month;
    utcloc_pkg::t_day   local_day;
    utcloc_pkg::t_hour  local_hour;

    modport source (output valid, output local_year, output local_month,
                    output local_day, output local_hour, input ready);
    modport sink   (input valid, input local_year, input local_month,
                    input local_day, input local_hour, output ready);
endinterface
`default_nettype wire

>>> rtl/utc_to_local_calendar_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utc_to_local_calendar_top
// Converts a UTC date and hour to local date and hour for a whole-hour offset.
// ----------------------------------------------------------------------------
//  Channel    Dir  Kind          Contents
//  i_utc      in   valid/ready   utc_year, utc_month, utc_day, utc_hour
//  o_local    out  valid/ready   local_year, local_month, local_day, local_hour
//  i_cfg_*    in   write only    zone_offset_hours (signed, 5 bits)
//
//  Two register stages: input register, then result register; the conversion
//  sits between them. One transfer per cycle sustained while o_local is ready.
//  Synchronous active-low reset clears valids and sets the offset to 0.
//  A stall on o_local holds both stages; i_utc.ready drops only when both full.
// ----------------------------------------------------------------------------
module utc_to_local_calendar_top (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [4:0]            i_cfg_wdata,
    utcloc_in_if.sink            i_utc,
    utcloc_out_if.source         o_local
);
    import utcloc_pkg::*;

    t_offset    r_zone;

    logic       r_s1_valid;
    t_year      r_year;
    t_raw_month r_month;
    t_day       r_day;
    t_hour      r_hour;

    logic       r_s2_valid;
    t_year      r_loc_year;
    t_month     r_loc_month;
    t_day       r_loc_day;
    t_hour      r_loc_hour;

    logic       w_s2_load;
    logic       w_s1_load;

    t_month          w_month;
    logic signed [6:0] w_hsum;
    logic signed [6:0] w_day;
    logic            w_carry;
    logic            w_borrow;
    logic            w_leap;
    t_day            w_dim;
    t_month          w_prev_month;

    t_year           n_year;
    t_month          n_month;
    t_day            n_day;
    t_hour           n_hour;

    assign w_s2_load     = r_s1_valid && (!r_s2_valid || o_local.ready);
    assign i_utc.ready   = !r_s1_valid || w_s2_load;
    assign w_s1_load     = i_utc.valid && i_utc.ready;

    assign o_local.valid       = r_s2_valid;
    assign o_local.local_year  = r_loc_year;
    assign o_local.local_month = r_loc_month;
    assign o_local.local_day   = r_loc_day;
    assign o_local.local_hour  = r_loc_hour;

    always_comb begin
        if (r_month == 8'd0) begin
            w_month = MONTH_JAN;
        end else if (r_month > 8'(MONTH_DEC)) begin
            w_month = MONTH_DEC;
        end else begin
            w_month = r_month[3:0];
        end

        w_hsum   = $signed({2'b00, r_hour}) + $signed({{2{r_zone[4]}}, r_zone});
        w_carry  = (w_hsum >= 7'sd24);
        w_borrow = (w_hsum < 7'sd0);
        if (w_carry) begin
            n_hour = 5'(w_hsum - 7'sd24);
        end else if (w_borrow) begin
            n_hour = 5'(w_hsum + 7'sd24);
        end else begin
            n_hour = 5'(w_hsum);
        end

        w_day = $signed({2'b00, r_day});
        if (w_carry) begin
            w_day = w_day + 7'sd1;
        end else if (w_borrow) begin
            w_day = w_day - 7'sd1;
        end

        w_leap       = is_leap(r_year);
        w_dim        = month_days(w_month, w_leap);
        w_prev_month = (w_month == MONTH_JAN) ? MONTH_DEC : 4'(w_month - 4'd1);

        n_year  = r_year;
        n_month = w_month;
        n_day   = 5'(w_day);
        if (w_day > $signed({2'b00, w_dim})) begin
            // one step into the next month only
            n_day = 5'd1;
            if (w_month == MONTH_DEC) begin
                n_month = MONTH_JAN;
                n_year  = 14'(r_year + 14'd1);
            end else begin
                n_month = 4'(w_month + 4'd1);
            end
        end else if (w_day < 7'sd1) begin
            // last day of previous month; February uses the input year's rule
            n_month = w_prev_month;
            n_day   = month_days(w_prev_month, w_leap);
            if (w_month == MONTH_JAN) begin
                n_year = 14'(r_year - 14'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone     <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_zone <= $signed(i_cfg_wdata);
            end
            if (i_utc.ready) begin
                r_s1_valid <= i_utc.valid;
            end
            if (w_s2_load) begin
                r_s2_valid <= 1'b1;
            end else if (o_local.ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_year  <= i_utc.utc_year;
            r_month <= i_utc.utc_month;
            r_day   <= i_utc.utc_day;
            r_hour  <= i_utc.utc_hour;
        end
        if (w_s2_load) begin
            r_loc_year  <= n_year;
            r_loc_month <= n_month;
            r_loc_day   <= n_day;
            r_loc_hour  <= n_hour;
        end
    end

endmodule
`default_nettype wire

>>> test/utc_to_local_calendar_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_to_local_calendar_top_test
// Drives UTC timestamps through the converter under a range of zone offsets.
// A directed table covers clamping, hour wrap, day and year rollover and the
// leap rule; random traffic with bursty idling on both channels follows. All
// results are checked field by field against typed or in-bench predictions.
// ----------------------------------------------------------------------------
module utc_to_local_calendar_top_test;
    import utcloc_pkg::*;

    typedef struct packed {
        t_year      year;
        t_raw_month month;
        t_day       day;
        t_hour      hour;
    } t_utc_item;

    typedef struct packed {
        t_year  year;
        t_month month;
        t_day   day;
        t_hour  hour;
    } t_local_item;

    typedef struct packed {
        t_offset     offset;
        t_utc_item   utc;
        bit          typed;
        t_local_item want;
    } t_case;

    localparam int HOURS_PER_DAY = 24;
    localparam int MONTHS        = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int CHUNKS        = 20;
    localparam int CHUNK_ITEMS   = 100;

    // want is typed in only where it reads straight off the calendar
    t_case directed_cases [24] = '{
        '{ 5'sd0,  '{14'd2024,  8'd6,   5'd15, 5'd12}, 1'b1, '{14'd2024,  4'd6,  5'd15, 5'd12}},
        '{ 5'sd0,  '{14'd1,     8'd1,   5'd1,  5'd0 }, 1'b1, '{14'd1,     4'd1,  5'd1,  5'd0 }},
        '{ 5'sd0,  '{14'd16383, 8'd255, 5'd31, 5'd23}, 1'b1, '{14'd16383, 4'd12, 5'd31, 5'd23}},
        '{ 5'sd0,  '{14'd0,     8'd0,   5'd0,  5'd0 }, 1'b1, '{14'd16383, 4'd12, 5'd31, 5'd0 }},
        '{ 5'sd0,  '{14'd2023,  8'd4,   5'd31, 5'd5 }, 1'b1, '{14'd2023,  4'd5,  5'd1,  5'd5 }},
        '{ 5'sd0,  '{14'd2023,  8'd1,   5'd1,  5'd31}, 1'b1, '{14'd2023,  4'd1,  5'd2,  5'd7 }},
        '{ 5'sd0,  '{14'd2000,  8'd2,   5'd29, 5'd10}, 1'b1, '{14'd2000,  4'd2,  5'd29, 5'd10}},
        '{ 5'sd0,  '{14'd1900,  8'd2,   5'd29, 5'd10}, 1'b1, '{14'd1900,  4'd3,  5'd1,  5'd10}},
        '{ 5'sd14, '{14'd2023,  8'd12,  5'd31, 5'd23}, 1'b1, '{14'd2024,  4'd1,  5'd1,  5'd13}},
        '{ 5'sd14, '{14'd16383, 8'd12,  5'd31, 5'd10}, 1'b1, '{14'd0,     4'd1,  5'd1,  5'd0 }},
        '{ 5'sd14, '{14'd2024,  8'd2,   5'd28, 5'd12}, 1'b1, '{14'd2024,  4'd2,  5'd29, 5'd2 }},
        '{ 5'sd14, '{14'd2023,  8'd2,   5'd28, 5'd12}, 1'b1, '{14'd2023,  4'd3,  5'd1,  5'd2 }},
        '{-5'sd12, '{14'd2024,  8'd1,   5'd1,  5'd5 }, 1'b1, '{14'd2023,  4'd12, 5'd31, 5'd17}},
        '{-5'sd12, '{14'd2024,  8'd3,   5'd1,  5'd0 }, 1'b1, '{14'd2024,  4'd2,  5'd29, 5'd12}},
        '{-5'sd12, '{14'd2100,  8'd3,   5'd1,  5'd3 }, 1'b1, '{14'd2100,  4'd2,  5'd28, 5'd15}},
        '{-5'sd12, '{14'd0,     8'd1,   5'd1,  5'd0 }, 1'b1, '{14'd16383, 4'd12, 5'd31, 5'd12}},
        '{-5'sd16, '{14'd2023,  8'd7,   5'd1,  5'd0 }, 1'b1, '{14'd2023,  4'd6,  5'd30, 5'd8 }},
        '{-5'sd16, '{14'd2023,  8'd200, 5'd15, 5'd20}, 1'b1, '{14'd2023,  4'd12, 5'd15, 5'd4 }},
        '{ 5'sd15, '{14'd2023,  8'd8,   5'd31, 5'd31}, 1'b1, '{14'd2023,  4'd9,  5'd1,  5'd22}},
        '{ 5'sd15, '{14'd2023,  8'd9,   5'd0,  5'd3 }, 1'b1, '{14'd2023,  4'd8,  5'd31, 5'd18}},
        '{ 5'sd15, '{14'd400,   8'd2,   5'd29, 5'd8 }, 1'b1, '{14'd400,   4'd2,  5'd29, 5'd23}},
        '{ 5'sd15, '{14'd2023,  8'd5,   5'd17, 5'd5 }, 1'b0, '{14'd0,     4'd0,  5'd0,  5'd0 }},
        '{ 5'sd5,  '{14'd9999,  8'd12,  5'd31, 5'd19}, 1'b0, '{14'd0,     4'd0,  5'd0,  5'd0 }},
        '{ 5'sd5,  '{14'd0,     8'd2,   5'd29, 5'd20}, 1'b0, '{14'd0,     4'd0,  5'd0,  5'd0 }}
    };

    int unsigned corner_years [8] = '{0, 1, 400, 1900, 2000, 2100, 9999, 16383};
    int unsigned corner_days  [6] = '{0, 1, 28, 29, 30, 31};

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [4:0] cfg_wdata;

    utcloc_in_if  utc_ch ();
    utcloc_out_if local_ch ();

    t_local_item conversions_due [$];
    t_offset     zone_offset = '0;
    bit          tx_idle;
    bit          rx_idle;
    bit          hold_request;
    int          error_count;
    int          items_sent;
    int          results_checked;
    int          offset_writes;
    int          date_shifts;

    utc_to_local_calendar_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_utc       (utc_ch),
        .o_local     (local_ch)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int days_in_month(input int mo, input t_year y);
        case (mo)
            2: begin
                return leap_year(y) ? 29 : 28;
            end
            4, 6, 9, 11: begin
                return 30;
            end
            default: begin
                return 31;
            end
        endcase
    endfunction

    function automatic t_local_item to_local(input t_offset off, input t_utc_item u);
        t_local_item r;
        int          mo;
        int          dy;
        int          hr;
        int unsigned yr;
        yr = u.year;
        mo = (u.month == 0) ? 1 : (u.month > MONTHS) ? MONTHS : int'(u.month);
        dy = u.day;
        hr = int'(u.hour) + int'(off);
        if (hr >= HOURS_PER_DAY) begin
            hr -= HOURS_PER_DAY;
            dy++;
        end else if (hr < 0) begin
            hr += HOURS_PER_DAY;
            dy--;
        end
        // only one roll step, even for a day that was already past month end
        if (dy > days_in_month(mo, u.year)) begin
            dy = 1;
            mo++;
            if (mo > MONTHS) begin
                mo = 1;
                yr = yr + 1;
            end
        end else if (dy < 1) begin
            mo--;
            if (mo < 1) begin
                mo = MONTHS;
                yr = yr - 1;
            end
            // leap rule follows the input year, not the rolled one
            dy = days_in_month(mo, u.year);
        end
        r.year  = t_year'(yr);
        r.month = t_month'(mo);
        r.day   = t_day'(dy);
        r.hour  = t_hour'(hr);
        return r;
    endfunction

    task automatic offer_utc(input t_utc_item it, input bit typed, input t_local_item want);
        t_local_item due;
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            utc_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        utc_ch.valid     <= 1'b1;
        utc_ch.utc_year  <= it.year;
        utc_ch.utc_month <= it.month;
        utc_ch.utc_day   <= it.day;
        utc_ch.utc_hour  <= it.hour;
        do @(posedge clk); while (utc_ch.ready !== 1'b1);
        due = typed ? want : to_local(zone_offset, it);
        conversions_due.push_back(due);
        items_sent++;
        if (due.day != it.day) begin
            date_shifts++;
        end
    endtask

    // offset only changes with both pipeline stages empty
    task automatic set_offset(input t_offset v);
        utc_ch.valid <= 1'b0;
        while (conversions_due.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we      <= 1'b0;
        zone_offset  = v;
        offset_writes++;
    endtask

    // result side: random ready bursts plus one long hold-off
    initial begin
        local_ch.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            if (hold_request) begin
                hold_request    = 1'b0;
                local_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (rx_idle && $urandom_range(0, 3) == 0) begin
                local_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end else begin
                local_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        t_local_item want;
        if (rst_n === 1'b1 && local_ch.valid === 1'b1 && local_ch.ready === 1'b1) begin
            if (conversions_due.size() == 0) begin
                $error("unexpected transfer: year %0d month %0d day %0d hour %0d",
                       local_ch.local_year, local_ch.local_month,
                       local_ch.local_day, local_ch.local_hour);
                error_count++;
            end else begin
                want = conversions_due.pop_front();
                results_checked++;
                if (local_ch.local_year !== want.year) begin
                    $error("local_year: expected %0d, got %0d", want.year, local_ch.local_year);
                    error_count++;
                end
                if (local_ch.local_month !== want.month) begin
                    $error("local_month: expected %0d, got %0d",
                           want.month, local_ch.local_month);
                    error_count++;
                end
                if (local_ch.local_day !== want.day) begin
                    $error("local_day: expected %0d, got %0d", want.day, local_ch.local_day);
                    error_count++;
                end
                if (local_ch.local_hour !== want.hour) begin
                    $error("local_hour: expected %0d, got %0d", want.hour, local_ch.local_hour);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_utc_item it;
        t_offset   off_pick;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        utc_ch.valid     <= 1'b0;
        utc_ch.utc_year  <= '0;
        utc_ch.utc_month <= '0;
        utc_ch.utc_day   <= '0;
        utc_ch.utc_hour  <= '0;
        tx_idle           = 1'b1;
        rx_idle           = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(directed_cases); i++) begin
            if (directed_cases[i].offset != zone_offset) begin
                set_offset(directed_cases[i].offset);
            end
            offer_utc(directed_cases[i].utc, directed_cases[i].typed, directed_cases[i].want);
        end

        for (int c = 0; c < CHUNKS; c++) begin
            case (c)
                0: begin
                    off_pick = -5'sd16;
                end
                1: begin
                    off_pick = 5'sd15;
                end
                2: begin
                    off_pick = 5'sd14;
                end
                3: begin
                    off_pick = -5'sd12;
                end
                default: begin
                    off_pick = t_offset'($urandom_range(0, 31));
                end
            endcase
            set_offset(off_pick);
            // every fourth chunk and the tail of the run go without idling
            tx_idle = (c < CHUNKS - 3) && (c % 4 != 3);
            rx_idle = (c < CHUNKS - 3) && (c % 4 != 3);
            if (c == 2) begin
                hold_request = 1'b1;
            end
            for (int k = 0; k < CHUNK_ITEMS; k++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        it.year = t_year'($urandom);
                    end
                    1: begin
                        it.year = t_year'(corner_years[$urandom_range(0, 7)]);
                    end
                    default: begin
                        it.year = t_year'($urandom_range(1, 9999));
                    end
                endcase
                it.month = ($urandom_range(0, 9) < 8) ? t_raw_month'($urandom_range(1, 12))
                                                      : t_raw_month'($urandom);
                it.day   = ($urandom_range(0, 2) == 0) ? t_day'(corner_days[$urandom_range(0, 5)])
                                                       : t_day'($urandom);
                it.hour  = ($urandom_range(0, 4) != 0) ? t_hour'($urandom_range(0, 23))
                                                       : t_hour'($urandom);
                offer_utc(it, 1'b0, '0);
            end
        end

        utc_ch.valid <= 1'b0;
        while (conversions_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Converted %0d timestamps under %0d offset settings, %0d moved to another day;",
                 items_sent, offset_writes, date_shifts);
        $display("%0d local results checked, %0d mismatches.", results_checked, error_count);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
